>>> rtl/mpc_pkg.sv
// ============================================================================
// mpc_pkg
// Shared types and constants for the moisture pump controller.
// ============================================================================
package mpc_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [DATA_W-1:0]   t_data;

    typedef enum logic [1:0] {
        CLASS_WET      = 2'd0,
        CLASS_MODERATE = 2'd1,
        CLASS_DRY      = 2'd2,
        CLASS_UNKNOWN  = 2'd3
    } t_class;

    typedef enum logic [2:0] {
        ACT_NONE            = 3'd0,
        ACT_WET_STOP        = 3'd1,
        ACT_RUN_ENDED       = 3'd2,
        ACT_RECHECK_RESTART = 3'd3,
        ACT_RECHECK_IDLE    = 3'd4,
        ACT_START           = 3'd5
    } t_action;

    // Register byte addresses
    localparam t_addr ADDR_WET_THRESHOLD = 4'h0;
    localparam t_addr ADDR_DRY_THRESHOLD = 4'h4;
    localparam t_addr ADDR_PUMP_RUN_MS   = 4'h8;
    localparam t_addr ADDR_WAIT_MS       = 4'hC;

    // Register reset values
    localparam t_sample RST_WET_THRESHOLD = 10'd800;
    localparam t_sample RST_DRY_THRESHOLD = 10'd500;
    localparam t_time   RST_PUMP_RUN_MS   = 32'd10000;
    localparam t_time   RST_WAIT_MS       = 32'd60000;

endpackage

>>> rtl/mpc_ifs.sv
// ============================================================================
// mpc channel interfaces
// Valid/ready channels for moisture samples and controller results.
// ============================================================================
interface mpc_in_if;
    logic              valid;
    logic              ready;
    mpc_pkg::t_sample  sample;
    mpc_pkg::t_time    now_ms;

    modport source (output valid, output sample, output now_ms, input ready);
    modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface mpc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  moisture_class;
    logic        lamp_red;
    logic        lamp_yellow;
    logic        lamp_green;
    logic        pump_on;
    logic [2:0]  action;

    modport source (output valid, output moisture_class, output lamp_red,
                    output lamp_yellow, output lamp_green, output pump_on,
                    output action, input ready);
    modport sink   (input valid, input moisture_class, input lamp_red,
                    input lamp_yellow, input lamp_green, input pump_on,
                    input action, output ready);
endinterface

>>> rtl/moisture_pump_controller_unit.sv
// Pipeline: the input register loads on the input transaction; classify/update
//   logic feeds the result register whenever the result slot is free.
// Throughput: 1 sample per cycle while o_out is not stalled; the controller
//   state updates in the same cycle the result register loads, so the next
//   sample sees it at once.
// Reset: synchronous active-low i_rst_n clears the pump sequence state,
//   marks the previous class unknown and restores the register defaults.
// ============================================================================
// moisture_pump_controller_unit
// Classifies moisture samples, drives the lamps and sequences the pump
// through run / wait / recheck phases with 32-bit wrapping millisecond timers.
// ============================================================================
module moisture_pump_controller_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // APB-style configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  mpc_pkg::t_addr      paddr,
    input  mpc_pkg::t_data      pwdata,
    output mpc_pkg::t_data      prdata,
    output logic                pready,
    // Sample and result channels
    mpc_in_if.sink              i_in,
    mpc_out_if.source           o_out
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    mpc_pkg::t_sample r_wet_threshold;
    mpc_pkg::t_sample r_dry_threshold;
    mpc_pkg::t_time   r_pump_run_ms;
    mpc_pkg::t_time   r_wait_ms;

    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet_threshold <= mpc_pkg::RST_WET_THRESHOLD;
            r_dry_threshold <= mpc_pkg::RST_DRY_THRESHOLD;
            r_pump_run_ms   <= mpc_pkg::RST_PUMP_RUN_MS;
            r_wait_ms       <= mpc_pkg::RST_WAIT_MS;
        end else if (cfg_wr) begin
            // Unmapped addresses are ignored
            case (paddr)
                mpc_pkg::ADDR_WET_THRESHOLD: begin
                    r_wet_threshold <= pwdata[mpc_pkg::SAMPLE_W-1:0];
                end
                mpc_pkg::ADDR_DRY_THRESHOLD: begin
                    r_dry_threshold <= pwdata[mpc_pkg::SAMPLE_W-1:0];
                end
                mpc_pkg::ADDR_PUMP_RUN_MS: begin
                    r_pump_run_ms <= pwdata;
                end
                mpc_pkg::ADDR_WAIT_MS: begin
                    r_wait_ms <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            mpc_pkg::ADDR_WET_THRESHOLD: prdata = {22'd0, r_wet_threshold};
            mpc_pkg::ADDR_DRY_THRESHOLD: prdata = {22'd0, r_dry_threshold};
            mpc_pkg::ADDR_PUMP_RUN_MS:   prdata = r_pump_run_ms;
            mpc_pkg::ADDR_WAIT_MS:       prdata = r_wait_ms;
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // Stage 1 holds the accepted sample; stage 2 is the result register.
    // Stage 1 fires into stage 2 whenever the result slot is empty or
    // being drained, so a stalled result holds the queued sample in stage 1.
    // ------------------------------------------------------------------
    logic             r_in_valid;
    mpc_pkg::t_sample r_in_sample;
    mpc_pkg::t_time   r_in_now;
    logic             r_out_valid;

    logic out_free;
    logic fire;
    logic in_take;

    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || fire;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sample <= i_in.sample;
            r_in_now    <= i_in.now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    logic            r_pump_running;
    logic            r_waiting;
    logic            r_origin_dry;
    mpc_pkg::t_class r_prev_class;
    mpc_pkg::t_time  r_run_start;
    mpc_pkg::t_time  r_wait_start;

    logic            n_pump_running;
    logic            n_waiting;
    logic            n_origin_dry;
    mpc_pkg::t_time  n_run_start;
    mpc_pkg::t_time  n_wait_start;
    mpc_pkg::t_class cur_class;
    mpc_pkg::t_action cur_action;
    mpc_pkg::t_time  run_elapsed;
    mpc_pkg::t_time  wait_elapsed;
    logic            demand;

    // Classification: the wet test wins even if the thresholds overlap
    always_comb begin
        if (r_in_sample >= r_wet_threshold) begin
            cur_class = mpc_pkg::CLASS_WET;
        end else if (r_in_sample <= r_dry_threshold) begin
            cur_class = mpc_pkg::CLASS_DRY;
        end else begin
            cur_class = mpc_pkg::CLASS_MODERATE;
        end
    end

    // Elapsed times wrap modulo 2^32
    assign run_elapsed  = r_in_now - r_run_start;
    assign wait_elapsed = r_in_now - r_wait_start;

    // Restart after the wait: dry, or moderate when this run cycle began dry
    assign demand = (cur_class == mpc_pkg::CLASS_DRY) ||
                    ((cur_class == mpc_pkg::CLASS_MODERATE) && r_origin_dry);

    always_comb begin
        n_pump_running = r_pump_running;
        n_waiting      = r_waiting;
        n_origin_dry   = r_origin_dry;
        n_run_start    = r_run_start;
        n_wait_start   = r_wait_start;
        cur_action     = mpc_pkg::ACT_NONE;

        if (cur_class == mpc_pkg::CLASS_WET) begin
            // Wet stops everything, every time
            n_pump_running = 1'b0;
            n_waiting      = 1'b0;
            n_origin_dry   = 1'b0;
            cur_action     = mpc_pkg::ACT_WET_STOP;
        end else if (r_pump_running) begin
            if (run_elapsed >= r_pump_run_ms) begin
                n_pump_running = 1'b0;
                n_waiting      = 1'b1;
                n_wait_start   = r_in_now;
                cur_action     = mpc_pkg::ACT_RUN_ENDED;
            end
        end else if (r_waiting) begin
            if (wait_elapsed >= r_wait_ms) begin
                n_waiting = 1'b0;
                if (demand) begin
                    n_pump_running = 1'b1;
                    n_run_start    = r_in_now;
                    cur_action     = mpc_pkg::ACT_RECHECK_RESTART;
                end else begin
                    n_origin_dry = 1'b0;
                    cur_action   = mpc_pkg::ACT_RECHECK_IDLE;
                end
            end
        end else if ((cur_class == mpc_pkg::CLASS_DRY) ||
                     ((cur_class == mpc_pkg::CLASS_MODERATE) &&
                      (r_prev_class == mpc_pkg::CLASS_DRY))) begin
            // Idle start: dry, or moderate right after a dry sample
            n_pump_running = 1'b1;
            n_run_start    = r_in_now;
            n_origin_dry   = (cur_class == mpc_pkg::CLASS_DRY);
            cur_action     = mpc_pkg::ACT_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_running <= 1'b0;
            r_waiting      <= 1'b0;
            r_origin_dry   <= 1'b0;
            r_prev_class   <= mpc_pkg::CLASS_UNKNOWN;
            r_run_start    <= '0;
            r_wait_start   <= '0;
        end else if (fire) begin
            r_pump_running <= n_pump_running;
            r_waiting      <= n_waiting;
            r_origin_dry   <= n_origin_dry;
            r_prev_class   <= cur_class;
            r_run_start    <= n_run_start;
            r_wait_start   <= n_wait_start;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    mpc_pkg::t_class  r_out_class;
    mpc_pkg::t_action r_out_action;
    logic             r_out_pump;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_class  <= cur_class;
            r_out_action <= cur_action;
            r_out_pump   <= n_pump_running;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.moisture_class = r_out_class;
    assign o_out.lamp_red       = (r_out_class == mpc_pkg::CLASS_DRY);
    assign o_out.lamp_yellow    = (r_out_class == mpc_pkg::CLASS_MODERATE);
    assign o_out.lamp_green     = (r_out_class == mpc_pkg::CLASS_WET);
    assign o_out.pump_on        = r_out_pump;
    assign o_out.action         = r_out_action;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_run_wait_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pump_running && r_waiting))
        else $error("pump running while waiting for recheck");

    a_pump_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pump == r_pump_running))
        else $error("reported pump level differs from pump state");

    a_wet_stop_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_class == mpc_pkg::CLASS_WET) ==
                         (r_out_action == mpc_pkg::ACT_WET_STOP)))
        else $error("wet class and wet-stop action disagree");

    a_start_runs_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_action == mpc_pkg::ACT_START) ||
                         (r_out_action == mpc_pkg::ACT_RECHECK_RESTART)))
        |-> r_out_pump)
        else $error("start action without pump running");

endmodule
